// ===== src/m4rm_pkg.sv =====
package m4rm_pkg;

    localparam int DIM            = 4;
    localparam int ELEM_W         = 32;
    localparam int ROW_W          = 2;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // row number plus DIM elements, padded to whole bytes
    localparam int TDATA_W = ((ROW_W + DIM * ELEM_W + 7) / 8) * 8;

    // lane pipeline: products, pair sums, total, shift and clamp
    localparam int LAT        = 4;
    localparam int FIFO_DEPTH = 8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MUL  = 1'b1;

    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              sat;
    } lane_res_t;

endpackage

// ===== src/m4rm_lane.sv =====
module m4rm_lane #(
    parameter int DATA_WIDTH = m4rm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m4rm_pkg::FRAC_BITS_DEF
) (
    input  logic                                                   aclk,
    input  logic [m4rm_pkg::DIM-1:0][m4rm_pkg::ELEM_W-1:0]         row_elems,
    input  logic [m4rm_pkg::DIM-1:0][DATA_WIDTH-1:0]               col_elems,
    output m4rm_pkg::lane_res_t                                    res
);
    import m4rm_pkg::*;

    localparam int PW    = 2 * DATA_WIDTH;
    localparam int SUM_W = PW + 2;

    logic signed [PW-1:0]    prod_reg [DIM];
    logic signed [PW:0]      pair_reg [DIM/2];
    logic signed [SUM_W-1:0] sum_reg;
    lane_res_t               res_reg;

    logic signed [SUM_W-1:0]           shifted;
    logic [SUM_W-DATA_WIDTH:0]         top_bits;
    logic                              in_range;
    logic signed [DATA_WIDTH-1:0]      clamped;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DIM; k++) begin
            prod_reg[k] <= $signed(row_elems[k][DATA_WIDTH-1:0]) * $signed(col_elems[k]);
        end
        for (int p = 0; p < DIM / 2; p++) begin
            pair_reg[p] <= (PW+1)'(prod_reg[2*p]) + (PW+1)'(prod_reg[2*p+1]);
        end
        sum_reg <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        res_reg <= '{value: ELEM_W'(clamped), sat: !in_range};
    end

    // floor rounding: arithmetic shift of the exact sum
    always_comb begin
        shifted  = sum_reg >>> FRAC_BITS;
        top_bits = shifted[SUM_W-1:DATA_WIDTH-1];
        in_range = (&top_bits) || !(|top_bits);
        if (in_range) begin
            clamped = shifted[DATA_WIDTH-1:0];
        end else if (shifted[SUM_W-1]) begin
            clamped = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            clamped = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    assign res = res_reg;

endmodule

// ===== src/m4rm_merge.sv =====
module m4rm_merge (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        push,
    input  logic [m4rm_pkg::ROW_W-1:0]                  row,
    input  m4rm_pkg::lane_res_t [m4rm_pkg::DIM-1:0]     lane_res,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [m4rm_pkg::TDATA_W-1:0]                m_tdata,
    output logic                                        m_tuser
);
    import m4rm_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [TDATA_W-1:0] data_mem [FIFO_DEPTH];
    logic               user_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic [TDATA_W-1:0] beat_data;
    logic               beat_sat;
    logic               pop;

    // gather lane results into one beat
    always_comb begin
        beat_data = '0;
        beat_sat  = 1'b0;
        beat_data[ROW_W-1:0] = row;
        for (int j = 0; j < DIM; j++) begin
            beat_data[ROW_W + j*ELEM_W +: ELEM_W] = lane_res[j].value;
            beat_sat = beat_sat | lane_res[j].sat;
        end
    end

    assign pop = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_mem[wr_ptr_reg] <= beat_data;
            user_mem[wr_ptr_reg] <= beat_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = data_mem[rd_ptr_reg];
    assign m_tuser  = user_mem[rd_ptr_reg];

endmodule

// ===== src/matrix4_row_multiply.sv =====
// Row-by-row 4x4 matrix multiply in signed fixed point (Q16.16 by default).
// A beat with s_tuser low loads row s_tdata[1:0] of the stored right-hand
// matrix and gives no output; a beat with s_tuser high carries a left-hand
// row and gives one result row: each column is the exact dot product with
// the stored column, floored by FRAC_BITS and clamped, m_tuser flagging a
// clamp. One beat is accepted per cycle while s_tready is high. Four column
// lanes of four multipliers each run a four-stage pipeline that feeds an
// 8-entry output buffer; the buffer absorbs stalls, and s_tready drops once
// 8 multiply rows are in flight or waiting. A load takes effect for a
// multiply beat accepted on the very next cycle.
module matrix4_row_multiply #(
    parameter int DATA_WIDTH = m4rm_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = m4rm_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [m4rm_pkg::TDATA_W-1:0]  s_tdata,  // row_index, elem_0..elem_3, zero pad
    input  logic                          s_tuser,  // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [m4rm_pkg::TDATA_W-1:0]  m_tdata,  // out_row, out_0..out_3, zero pad
    output logic                          m_tuser   // saturated
);
    import m4rm_pkg::*;

    localparam int INFL_W = $clog2(FIFO_DEPTH + 1);

    logic [DATA_WIDTH-1:0]        mat_reg [DIM][DIM];
    logic [LAT-1:0]               vld_reg;
    logic [ROW_W-1:0]             row_reg [LAT];
    logic [INFL_W-1:0]            inflight_reg, inflight_next;

    logic [DIM-1:0][ELEM_W-1:0]   row_elems;
    lane_res_t [DIM-1:0]          lane_res;
    logic                         s_accept;
    logic                         acc_mul;
    logic                         acc_load;
    logic                         m_pop;
    logic [ROW_W-1:0]             s_row;

    assign s_tready = (inflight_reg != INFL_W'(FIFO_DEPTH));
    assign s_accept = s_tvalid && s_tready;
    assign acc_mul  = s_accept && (s_tuser == FUNC_MUL);
    assign acc_load = s_accept && (s_tuser == FUNC_LOAD);
    assign m_pop    = m_tvalid && m_tready;
    assign s_row    = s_tdata[ROW_W-1:0];

    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            row_elems[k] = s_tdata[ROW_W + k*ELEM_W +: ELEM_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    mat_reg[r][c] <= '0;
                end
            end
        end else if (acc_load) begin
            for (int c = 0; c < DIM; c++) begin
                mat_reg[s_row][c] <= row_elems[c][DATA_WIDTH-1:0];
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < DIM; j++) begin : g_lane
            logic [DIM-1:0][DATA_WIDTH-1:0] col_elems;

            always_comb begin
                for (int k = 0; k < DIM; k++) begin
                    col_elems[k] = mat_reg[k][j];
                end
            end

            m4rm_lane #(
                .DATA_WIDTH (DATA_WIDTH),
                .FRAC_BITS  (FRAC_BITS)
            ) u_lane (
                .aclk      (aclk),
                .row_elems (row_elems),
                .col_elems (col_elems),
                .res       (lane_res[j])
            );
        end
    endgenerate

    // row number rides alongside the lane pipeline
    always_ff @(posedge aclk) begin
        row_reg[0] <= s_row;
        for (int s = 1; s < LAT; s++) begin
            row_reg[s] <= row_reg[s-1];
        end
    end

    always_comb begin
        inflight_next = inflight_reg + INFL_W'(acc_mul) - INFL_W'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            inflight_reg <= '0;
        end else begin
            vld_reg      <= {vld_reg[LAT-2:0], acc_mul};
            inflight_reg <= inflight_next;
        end
    end

    m4rm_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (vld_reg[LAT-1]),
        .row      (row_reg[LAT-1]),
        .lane_res (lane_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= INFL_W'(FIFO_DEPTH))
        else $error("in-flight count beyond buffer depth");

    a_out_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (inflight_reg != '0))
        else $error("output beat without an item in flight");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_load |=> !vld_reg[0])
        else $error("load beat entered the multiply pipeline");

endmodule

// ===== test/matrix4_row_multiply_test.sv =====
`timescale 1ns / 100ps

module matrix4_row_multiply_test;

    import m4rm_pkg::*;

    localparam logic [31:0] ONE_Q  = 32'h0001_0000;
    localparam logic [31:0] MAX_Q  = 32'h7fff_ffff;
    localparam logic [31:0] MIN_Q  = 32'h8000_0000;
    localparam logic [31:0] NEG_LSB = 32'hffff_ffff;
    localparam logic signed [65:0] SUM_MAX = 66'sh0_7fff_ffff;
    localparam logic signed [65:0] SUM_MIN = -SUM_MAX - 66'sd1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 730;

    typedef logic [3:0][31:0] row_elems_t;

    typedef struct packed {
        logic [1:0] row;
        row_elems_t cols;
        logic       sat;
    } product_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;

    row_elems_t   right_rows [4];
    product_row_t pending_products [$];
    int           mismatches;
    int           cycle_count;
    int           stall_left;
    bit           idle_on;

    matrix4_row_multiply uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // row_index, elem_0..elem_3, zero pad
        .s_tuser  (s_tuser),   // func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // out_row, out_0..out_3, zero pad
        .m_tuser  (m_tuser)    // saturated
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic row_elems_t mk_row(input logic [31:0] c0, input logic [31:0] c1,
                                          input logic [31:0] c2, input logic [31:0] c3);
        row_elems_t e;
        e[0] = c0;
        e[1] = c1;
        e[2] = c2;
        e[3] = c3;
        return e;
    endfunction

    // Exact dot products, floor by 16 fraction bits, clamp to 32-bit range.
    function automatic product_row_t product_of_row(input logic [1:0] row,
                                                    input row_elems_t elems);
        product_row_t r;
        logic signed [65:0] acc;
        logic signed [65:0] a;
        logic signed [65:0] b;
        r.row = row;
        r.sat = 1'b0;
        for (int j = 0; j < 4; j++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
                a = $signed(elems[k]);
                b = $signed(right_rows[k][j]);
                acc = acc + a * b;
            end
            acc = acc >>> 16;
            if (acc > SUM_MAX) begin
                r.cols[j] = MAX_Q;
                r.sat = 1'b1;
            end else if (acc < SUM_MIN) begin
                r.cols[j] = MIN_Q;
                r.sat = 1'b1;
            end else begin
                r.cols[j] = acc[31:0];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: begin
                case ($urandom_range(0, 4))
                    0: return MAX_Q;
                    1: return MIN_Q;
                    2: return NEG_LSB;
                    3: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic row_elems_t rand_row();
        return mk_row(rand_elem(), rand_elem(), rand_elem(), rand_elem());
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %h, expected %h (cycle %0d)",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Drive one beat at the falling edge and hold it until accepted.
    task automatic send_row(input logic func, input logic [1:0] row, input row_elems_t elems);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = '0;
        s_tdata[1:0] = row;
        for (int k = 0; k < 4; k++) s_tdata[2 + 32 * k +: 32] = elems[k];
        do @(posedge aclk); while (!s_tready);
        if (func == FUNC_LOAD) begin
            if (row < DIM) right_rows[row] = elems;
        end else begin
            pending_products.push_back(product_of_row(row, elems));
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_products.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_tready = 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        product_row_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_products.size() == 0) begin
                report_mismatch("unexpected result row", {30'b0, m_tdata[1:0]}, 32'b0);
            end else begin
                want = pending_products.pop_front();
                if (m_tdata[1:0] !== want.row)
                    report_mismatch("out_row", {30'b0, m_tdata[1:0]}, {30'b0, want.row});
                for (int j = 0; j < 4; j++)
                    if (m_tdata[2 + 32 * j +: 32] !== want.cols[j])
                        report_mismatch($sformatf("out_%0d", j),
                                        m_tdata[2 + 32 * j +: 32], want.cols[j]);
                if (m_tuser !== want.sat)
                    report_mismatch("saturated", {31'b0, m_tuser}, {31'b0, want.sat});
            end
        end
    end

    // Nothing loaded yet: every product reads zero.
    task automatic test_unwritten_rows();
        send_row(FUNC_MUL, 2'd3, mk_row(MAX_Q, MIN_Q, NEG_LSB, ONE_Q));
        send_row(FUNC_MUL, 2'd0, mk_row(MAX_Q, MAX_Q, MAX_Q, MAX_Q));
    endtask

    task automatic test_identity();
        row_elems_t e;
        for (int r = 0; r < 4; r++) begin
            e = '0;
            e[r] = ONE_Q;
            send_row(FUNC_LOAD, r[1:0], e);
        end
        send_row(FUNC_MUL, 2'd0, mk_row(MAX_Q, MIN_Q, NEG_LSB, 32'h0000_0001));
        send_row(FUNC_MUL, 2'd1, mk_row(MIN_Q, MAX_Q, 32'h0000_0001, NEG_LSB));
        send_row(FUNC_MUL, 2'd2, mk_row(32'h5555_5555, 32'haaaa_aaaa, 0, ONE_Q));
        send_row(FUNC_MUL, 2'd3, mk_row(32'haaaa_aaaa, 32'h5555_5555, ONE_Q, 0));
    endtask

    // Tiny negative sums floor to -1, tiny positive ones to 0.
    task automatic test_floor_rounding();
        for (int r = 0; r < 4; r++)
            send_row(FUNC_LOAD, r[1:0], mk_row(1, 1, 1, 1));
        send_row(FUNC_MUL, 2'd1, mk_row(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB));
        send_row(FUNC_MUL, 2'd2, mk_row(1, 1, 1, 0));
    endtask

    task automatic test_saturation();
        for (int r = 0; r < 4; r++)
            send_row(FUNC_LOAD, r[1:0], mk_row(MAX_Q, MIN_Q, ONE_Q, 0));
        send_row(FUNC_MUL, 2'd0, mk_row(MAX_Q, MAX_Q, MAX_Q, MAX_Q));
        send_row(FUNC_MUL, 2'd3, mk_row(ONE_Q, 0, 0, 0));
        send_row(FUNC_MUL, 2'd2, mk_row(MIN_Q, MIN_Q, MIN_Q, MIN_Q));
    endtask

    // Mostly multiplies, with whole-matrix loads and stray single-row loads mixed in.
    task automatic test_random_traffic();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = (sent < RANDOM_ITEMS - 150) && (((sent / 60) % 3) != 2);
            if (sent >= 350 && sent < 360) begin
                wait_drained();
                sent = 360;
            end
            case ($urandom_range(0, 7))
                0: begin
                    for (int r = 0; r < 4; r++)
                        send_row(FUNC_LOAD, r[1:0], rand_row());
                    sent += 4;
                end
                1: begin
                    send_row(FUNC_LOAD, 2'($urandom_range(0, 3)), rand_row());
                    sent++;
                end
                default: begin
                    send_row(FUNC_MUL, 2'($urandom_range(0, 3)), rand_row());
                    sent++;
                end
            endcase
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_LOAD;
        m_tready    = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        stall_left  = 0;
        idle_on     = 1'b1;
        for (int r = 0; r < 4; r++) right_rows[r] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_unwritten_rows();
        test_identity();
        test_floor_rounding();
        test_saturation();
        test_random_traffic();

        wait_drained();
        repeat (LAT * 4) @(negedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== matrix4_row_multiply.f =====
src/m4rm_pkg.sv
src/m4rm_lane.sv
src/m4rm_merge.sv
src/matrix4_row_multiply.sv
test/matrix4_row_multiply_test.sv
